// ===== hw/rtl/sprite_quad_setup_unit_assert.svh =====
// assertion macros for the sprite quad setup unit
`ifndef SPRITE_QUAD_SETUP_UNIT_ASSERT_SVH
`define SPRITE_QUAD_SETUP_UNIT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SQS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SQS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/sqs_pkg.sv =====
// shared types, constants and sine table functions of the sprite quad setup unit
package sqs_pkg;

    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam int TRIG_FRAC_BITS_DEF  = 15;

    localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
    localparam longint unsigned ONE_Q30    = 64'd1 << 30;

    // draw flag bit positions
    localparam int FLAG_LEFT  = 0;
    localparam int FLAG_RIGHT = 1;
    localparam int FLAG_DOWN  = 2;
    localparam int FLAG_UP    = 3;
    localparam int FLAG_FLIPX = 4;
    localparam int FLAG_FLIPY = 5;

    // corner codes in emission order
    localparam logic [1:0] CORNER_LB = 2'd0;
    localparam logic [1:0] CORNER_RB = 2'd1;
    localparam logic [1:0] CORNER_RT = 2'd2;
    localparam logic [1:0] CORNER_LT = 2'd3;

    typedef struct packed {
        logic [15:0]        sprite_width;
        logic [15:0]        sprite_height;
        logic [15:0]        tex_left;
        logic [15:0]        tex_top;
        logic [15:0]        tex_width;
        logic [15:0]        tex_height;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [15:0]        draw_scale;
        logic [15:0]        turn_angle;
        logic [5:0]         draw_flags;
        logic [31:0]        tint_color;
    } t_req;

    typedef struct packed {
        logic signed [31:0] vert_x;
        logic signed [31:0] vert_y;
        logic [16:0]        tex_u;
        logic [16:0]        tex_v;
        logic [31:0]        corner_color;
        logic [1:0]         corner_index;
        logic               last_corner;
    } t_vert;

    // one corner handed to the pipe
    typedef struct packed {
        t_req       req;
        logic [1:0] corner;
    } t_issue;

    // fields that ride along the pipe untouched
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [16:0]        tex_u;
        logic [16:0]        tex_v;
        logic [31:0]        color;
        logic [1:0]         corner;
    } t_side;

    function automatic longint unsigned series_sin(input longint unsigned x);
        longint unsigned x2;
        longint unsigned t;
        longint signed   sum;
        x2 = (x * x) >> 30;
        t = x;
        sum = longint'(x);
        t = ((t * x2) >> 30) / 6;   sum = sum - longint'(t);
        t = ((t * x2) >> 30) / 20;  sum = sum + longint'(t);
        t = ((t * x2) >> 30) / 42;  sum = sum - longint'(t);
        t = ((t * x2) >> 30) / 72;  sum = sum + longint'(t);
        t = ((t * x2) >> 30) / 110; sum = sum - longint'(t);
        return longint'(unsigned'(sum));
    endfunction

    function automatic longint unsigned series_cos(input longint unsigned x);
        longint unsigned x2;
        longint unsigned t;
        longint signed   sum;
        x2 = (x * x) >> 30;
        t = ONE_Q30;
        sum = longint'(ONE_Q30);
        t = ((t * x2) >> 30) / 2;   sum = sum - longint'(t);
        t = ((t * x2) >> 30) / 12;  sum = sum + longint'(t);
        t = ((t * x2) >> 30) / 30;  sum = sum - longint'(t);
        t = ((t * x2) >> 30) / 56;  sum = sum + longint'(t);
        t = ((t * x2) >> 30) / 90;  sum = sum - longint'(t);
        t = ((t * x2) >> 30) / 132; sum = sum + longint'(t);
        return longint'(unsigned'(sum));
    endfunction

    // sine of r table steps over the first quadrant, evaluated at elaboration
    function automatic longint unsigned quarter_sine(input int r, input int bits,
                                                     input int frac);
        longint unsigned n4;
        longint unsigned n8;
        longint unsigned x;
        longint unsigned v;
        longint unsigned rr;
        n4 = 64'd1 << (bits - 2);
        n8 = n4 >> 1;
        rr = longint'(unsigned'(r));
        if (rr <= n8) begin
            x = (rr * TWO_PI_Q30 + (64'd1 << (bits - 1))) >> bits;
            v = series_sin(x);
        end else begin
            x = ((n4 - rr) * TWO_PI_Q30 + (64'd1 << (bits - 1))) >> bits;
            v = series_cos(x);
        end
        return (v + (64'd1 << (29 - frac))) >> (30 - frac);
    endfunction

endpackage

// ===== hw/rtl/sqs_chan_if.sv =====
// valid/ready channel carrying one word of a given payload type
interface sqs_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/sqs_corner_pipe.sv =====
// five-stage corner pipe: trig lookup, extents, rotation products, rounding, translate
module sqs_corner_pipe #(
    parameter int SINE_TABLE_BITS = sqs_pkg::SINE_TABLE_BITS_DEF,
    parameter int TRIG_FRAC_BITS  = sqs_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_issue_v,
    input  sqs_pkg::t_issue  i_issue,
    output logic             o_issue_rdy,
    sqs_chan_if.source       o_vert
);

    localparam int B   = SINE_TABLE_BITS;
    localparam int T   = TRIG_FRAC_BITS;
    localparam int N4  = 1 << (B - 2);
    localparam int QW  = T + 1;
    localparam int TW  = T + 2;
    localparam int LW  = 34;
    localparam int PW  = LW + TW;
    localparam int SW  = PW + 1;
    localparam int RS  = T - 3;
    localparam int RW  = SW - RS;
    localparam int XW  = RW + 1;
    localparam logic signed [SW-1:0] RND_HALF = {{(SW-1){1'b0}}, 1'b1} << (RS - 1);

    // quarter-wave table, one more entry than the quadrant for the peak
    logic [QW-1:0] w_qtab [0:N4];
    for (genvar g = 0; g <= N4; g++) begin : g_qtab
        assign w_qtab[g] = QW'(sqs_pkg::quarter_sine(g, B, T));
    end

    logic       r_v [0:4];
    logic       w_adv;
    sqs_pkg::t_side r_side [0:3];

    assign w_adv       = !r_v[4] || o_vert.ready;
    assign o_issue_rdy = w_adv;

    // stage a inputs
    logic [15:0]     w_ang;
    logic [B-1:0]    w_idx_s;
    logic [B-1:0]    w_idx_c;
    logic signed [TW-1:0] w_sn;
    logic signed [TW-1:0] w_cs;
    logic            w_left;
    logic            w_bot;
    logic [16:0]     w_ul;
    logic [16:0]     w_ur;
    logic [16:0]     w_vt;
    logic [16:0]     w_vb;
    sqs_pkg::t_req   w_rq;

    function automatic logic signed [TW-1:0] sine_at(input logic [B-1:0] idx,
                                                     input logic [QW-1:0] tab [0:N4]);
        logic [B-2:0]  addr;
        logic [B-2:0]  rem;
        logic [QW-1:0] mag;
        rem = {1'b0, idx[B-3:0]};
        addr = idx[B-2] ? ((B-1)'(N4) - rem) : rem;
        mag = tab[addr];
        return idx[B-1] ? -TW'(mag) : TW'(mag);
    endfunction

    assign w_rq    = i_issue.req;
    assign w_ang   = 16'(~w_rq.turn_angle + 16'd1);
    assign w_idx_s = w_ang[15 -: B];
    assign w_idx_c = w_idx_s + B'(N4);
    assign w_sn    = sine_at(w_idx_s, w_qtab);
    assign w_cs    = sine_at(w_idx_c, w_qtab);
    assign w_left  = (i_issue.corner == sqs_pkg::CORNER_LB)
                  || (i_issue.corner == sqs_pkg::CORNER_LT);
    assign w_bot   = (i_issue.corner == sqs_pkg::CORNER_LB)
                  || (i_issue.corner == sqs_pkg::CORNER_RB);

    always_comb begin
        if (w_rq.draw_flags[sqs_pkg::FLAG_FLIPX]) begin
            w_ur = {1'b0, w_rq.tex_left};
            w_ul = {1'b0, w_rq.tex_left} + {1'b0, w_rq.tex_width};
        end else begin
            w_ul = {1'b0, w_rq.tex_left};
            w_ur = {1'b0, w_rq.tex_left} + {1'b0, w_rq.tex_width};
        end
        if (w_rq.draw_flags[sqs_pkg::FLAG_FLIPY]) begin
            w_vb = {1'b0, w_rq.tex_top};
            w_vt = {1'b0, w_rq.tex_top} + {1'b0, w_rq.tex_height};
        end else begin
            w_vt = {1'b0, w_rq.tex_top};
            w_vb = {1'b0, w_rq.tex_top} + {1'b0, w_rq.tex_height};
        end
    end

    // stage registers
    logic [31:0]          r_hx;
    logic [31:0]          r_hy;
    logic [3:0]           r_align;
    logic                 r_left;
    logic                 r_bot;
    logic signed [TW-1:0] r_sn_a;
    logic signed [TW-1:0] r_cs_a;
    logic signed [LW-1:0] r_lx;
    logic signed [LW-1:0] r_ly;
    logic signed [TW-1:0] r_sn_b;
    logic signed [TW-1:0] r_cs_b;
    logic signed [PW-1:0] r_pxc;
    logic signed [PW-1:0] r_pys;
    logic signed [PW-1:0] r_pxs;
    logic signed [PW-1:0] r_pyc;
    logic signed [RW-1:0] r_rx;
    logic signed [RW-1:0] r_ry;
    sqs_pkg::t_vert       r_out;

    // stage b combinational
    logic signed [LW-1:0] n_lx;
    logic signed [LW-1:0] n_ly;
    logic signed [LW-1:0] w_hx1;
    logic signed [LW-1:0] w_hx2;
    logic signed [LW-1:0] w_hy1;
    logic signed [LW-1:0] w_hy2;

    assign w_hx1 = {2'b00, r_hx};
    assign w_hx2 = {1'b0, r_hx, 1'b0};
    assign w_hy1 = {2'b00, r_hy};
    assign w_hy2 = {1'b0, r_hy, 1'b0};

    always_comb begin
        // left beats right, down beats up, else centred
        if (r_align[sqs_pkg::FLAG_LEFT]) begin
            n_lx = r_left ? '0 : w_hx2;
        end else if (r_align[sqs_pkg::FLAG_RIGHT]) begin
            n_lx = r_left ? -w_hx2 : '0;
        end else begin
            n_lx = r_left ? -w_hx1 : w_hx1;
        end
        if (r_align[sqs_pkg::FLAG_DOWN]) begin
            n_ly = r_bot ? '0 : w_hy2;
        end else if (r_align[sqs_pkg::FLAG_UP]) begin
            n_ly = r_bot ? -w_hy2 : '0;
        end else begin
            n_ly = r_bot ? -w_hy1 : w_hy1;
        end
    end

    // stage d combinational
    logic signed [SW-1:0] w_sx;
    logic signed [SW-1:0] w_sy;
    logic signed [SW-1:0] w_shx;
    logic signed [SW-1:0] w_shy;

    assign w_sx  = SW'(r_pxc) - SW'(r_pys) + RND_HALF;
    assign w_sy  = SW'(r_pxs) + SW'(r_pyc) + RND_HALF;
    assign w_shx = w_sx >>> RS;
    assign w_shy = w_sy >>> RS;

    // stage e combinational
    logic signed [XW-1:0] w_tx;
    logic signed [XW-1:0] w_ty;

    assign w_tx = XW'(r_rx) + XW'(r_side[3].pos_x);
    assign w_ty = XW'(r_ry) + XW'(r_side[3].pos_y);

    function automatic logic [31:0] sat32(input logic signed [XW-1:0] v);
        if (!v[XW-1] && (|v[XW-2:31])) begin
            return 32'h7FFF_FFFF;
        end else if (v[XW-1] && !(&v[XW-2:31])) begin
            return 32'h8000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 5; i++) begin
                r_v[i] <= 1'b0;
            end
        end else if (w_adv) begin
            r_v[0] <= i_issue_v;
            for (int i = 1; i < 5; i++) begin
                r_v[i] <= r_v[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_side[0].pos_x  <= w_rq.pos_x;
            r_side[0].pos_y  <= w_rq.pos_y;
            r_side[0].tex_u  <= w_left ? w_ul : w_ur;
            r_side[0].tex_v  <= w_bot ? w_vb : w_vt;
            r_side[0].color  <= w_rq.tint_color;
            r_side[0].corner <= i_issue.corner;
            for (int i = 1; i < 4; i++) begin
                r_side[i] <= r_side[i-1];
            end
            r_hx    <= 32'(w_rq.sprite_width) * 32'(w_rq.draw_scale);
            r_hy    <= 32'(w_rq.sprite_height) * 32'(w_rq.draw_scale);
            r_align <= w_rq.draw_flags[3:0];
            r_left  <= w_left;
            r_bot   <= w_bot;
            r_sn_a  <= w_sn;
            r_cs_a  <= w_cs;

            r_lx   <= n_lx;
            r_ly   <= n_ly;
            r_sn_b <= r_sn_a;
            r_cs_b <= r_cs_a;

            r_pxc <= r_lx * r_cs_b;
            r_pys <= r_ly * r_sn_b;
            r_pxs <= r_lx * r_sn_b;
            r_pyc <= r_ly * r_cs_b;

            r_rx <= w_shx[RW-1:0];
            r_ry <= w_shy[RW-1:0];

            r_out.vert_x       <= sat32(w_tx);
            r_out.vert_y       <= sat32(w_ty);
            r_out.tex_u        <= r_side[3].tex_u;
            r_out.tex_v        <= r_side[3].tex_v;
            r_out.corner_color <= r_side[3].color;
            r_out.corner_index <= r_side[3].corner;
            r_out.last_corner  <= (r_side[3].corner == sqs_pkg::CORNER_LT);
        end
    end

    assign o_vert.valid = r_v[4];
    assign o_vert.data  = r_out;

endmodule

// ===== hw/rtl/sprite_quad_setup_unit.sv =====
// top level of the sprite quad setup unit: request hold, corner sequencing, corner pipe
//
// Takes one sprite draw request and gives its four corner vertices in the order
// left-bottom, right-bottom, right-top, left-top, the last one flagged. One request
// is held until its four corners are issued through the single result port, which emits
// one corner per cycle while the result side does not stall; a request is accepted while
// the fourth corner of the previous one is being issued. Each corner passes a five-stage
// pipe before it is presented. A stall on the result side holds the whole pipe without
// losing or repeating a corner.
`include "sprite_quad_setup_unit_assert.svh"

module sprite_quad_setup_unit #(
    parameter int SINE_TABLE_BITS = sqs_pkg::SINE_TABLE_BITS_DEF,
    parameter int TRIG_FRAC_BITS  = sqs_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sqs_chan_if.sink   i_req,
    sqs_chan_if.source o_vert
);

    logic            r_hold;
    logic [1:0]      r_k;
    sqs_pkg::t_req   r_req;
    sqs_pkg::t_issue w_issue;
    logic            w_adv;
    logic            w_take;

    assign w_take      = i_req.valid && i_req.ready;
    assign i_req.ready = !r_hold || ((r_k == sqs_pkg::CORNER_LT) && w_adv);

    assign w_issue.req    = r_req;
    assign w_issue.corner = r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= 1'b0;
            r_k    <= sqs_pkg::CORNER_LB;
        end else if (w_take) begin
            r_hold <= 1'b1;
            r_k    <= sqs_pkg::CORNER_LB;
        end else if (r_hold && w_adv) begin
            r_k <= r_k + 2'd1;
            if (r_k == sqs_pkg::CORNER_LT) begin
                r_hold <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_req <= i_req.data;
        end
    end

    sqs_corner_pipe #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .TRIG_FRAC_BITS  (TRIG_FRAC_BITS)
    ) u_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_issue_v   (r_hold),
        .i_issue     (w_issue),
        .o_issue_rdy (w_adv),
        .o_vert      (o_vert)
    );

    `SQS_ASSERT_IMP(a_last_flag, o_vert.valid, o_vert.data.last_corner == (o_vert.data.corner_index == sqs_pkg::CORNER_LT), "last flag does not match corner")
    `SQS_ASSERT_IMP(a_take_free, w_take, !r_hold || (r_k == sqs_pkg::CORNER_LT), "request taken while corners still pending")
    `SQS_ASSERT_NXT(a_take_start, w_take, r_hold && (r_k == sqs_pkg::CORNER_LB), "new request did not start at first corner")

endmodule
